// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while reset is high.
`define PET_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define PET_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/pet_pkg.sv -----
// Types, codes and reset values shared by the pointer event tracker.
`timescale 1ns / 1ps
package pet_pkg;

  // Fixed field widths.
  localparam int POS_W   = 12;
  localparam int DIM_W   = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Event classes.
  localparam logic [4:0] EV_BUTTON = 5'd1;
  localparam logic [4:0] EV_MOTION = 5'd2;

  // Axis and button codes.
  localparam logic [9:0] CODE_X      = 10'd0;
  localparam logic [9:0] CODE_Y      = 10'd1;
  localparam logic [9:0] CODE_WHEEL  = 10'd8;
  localparam logic [9:0] CODE_LEFT   = 10'd272;
  localparam logic [9:0] CODE_RIGHT  = 10'd273;
  localparam logic [9:0] CODE_MIDDLE = 10'd274;

  // Rotation codes that invert an axis.
  localparam logic [1:0] ROT_INV_X = 2'd1;
  localparam logic [1:0] ROT_INV_Y = 2'd3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH    = 3'd0,
    REG_SCREEN_HEIGHT   = 3'd1,
    REG_ROTATION        = 3'd2,
    REG_WHEEL_STEP      = 3'd3,
    REG_DOUBLE_CLICK_MS = 3'd4
  } cfg_reg_t;

  // Register reset values.
  localparam logic [DIM_W-1:0] RST_SCREEN_WIDTH    = 13'd800;
  localparam logic [DIM_W-1:0] RST_SCREEN_HEIGHT   = 13'd480;
  localparam logic [1:0]       RST_ROTATION        = 2'd0;
  localparam logic [15:0]      RST_WHEEL_STEP      = 16'd1;
  localparam logic [15:0]      RST_DOUBLE_CLICK_MS = 16'd300;

  typedef struct packed {
    logic [4:0]         event_type;
    logic [9:0]         event_code;
    logic signed [31:0] event_value;
    logic [31:0]        time_ms;
  } event_t;

  typedef struct packed {
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic               pressed;
    logic               button_id;
    logic               double_click;
    logic               activity;
    logic signed [31:0] wheel_turn;
    logic signed [47:0] tune_delta;
    logic               step_change_req;
  } result_t;

  typedef struct packed {
    logic [DIM_W-1:0] screen_width;
    logic [DIM_W-1:0] screen_height;
    logic [1:0]       rotation;
    logic [15:0]      wheel_step;
    logic [15:0]      double_click_ms;
  } cfg_t;

endpackage

// ----- rtl/core/pointer_event_tracker.sv -----
// Pointer event tracker top level: event register, result register, settings.
//
// Channels: evt carries one input event per beat (valid/stall), res carries
// one result per event (valid/stall), cfg writes one setting per beat
// (valid/ready, always ready) by index: 0 screen_width, 1 screen_height,
// 2 rotation, 3 wheel_step, 4 double_click_ms.
// An accepted event waits in the event register and moves into the result
// register once that register is free or draining.
// Throughput: one event per cycle unless res stalls; the single pass through
// the axis adders, clamps, gap compare and 17x32 wheel multiplier sets it.
// A held result does not stop intake: the event register still takes one
// more event, and evt stalls only while both registers are full and res
// is stalled.
// Reset: settings return to 800x480, rotation 0, step 1, 300 ms; cursor,
// buttons and the click detector clear; both registers empty. The user must
// write settings only while no event is in flight; it is not enforced.
`timescale 1ns / 1ps
module pointer_event_tracker #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         evt_valid,
  output logic                         evt_stall,
  input  pet_pkg::event_t              evt,
  output logic                         res_valid,
  input  logic                         res_stall,
  output pet_pkg::result_t             res,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pet_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pet_pkg::*;

  cfg_t    cfg;
  event_t  evt_q;
  logic    evt_q_valid;
  logic    advance;
  result_t res_comb;

  // Move the held event on when the result register is free or draining
  assign advance   = evt_q_valid && (!res_valid || !res_stall);
  assign evt_stall = evt_q_valid && !advance;
  assign cfg_ready = 1'b1;

  // Settings registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width    <= RST_SCREEN_WIDTH;
      cfg.screen_height   <= RST_SCREEN_HEIGHT;
      cfg.rotation        <= RST_ROTATION;
      cfg.wheel_step      <= RST_WHEEL_STEP;
      cfg.double_click_ms <= RST_DOUBLE_CLICK_MS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:    cfg.screen_width    <= cfg_data[DIM_W-1:0];
        REG_SCREEN_HEIGHT:   cfg.screen_height   <= cfg_data[DIM_W-1:0];
        REG_ROTATION:        cfg.rotation        <= cfg_data[1:0];
        REG_WHEEL_STEP:      cfg.wheel_step      <= cfg_data;
        REG_DOUBLE_CLICK_MS: cfg.double_click_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Event register
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_q_valid <= 1'b0;
    end else if (evt_valid && !evt_stall) begin
      evt_q_valid <= 1'b1;
    end else if (advance) begin
      evt_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && !evt_stall) begin
      evt_q <= evt;
    end
  end

  pet_core #(.COORD_BITS(COORD_BITS)) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .evt  (evt_q),
    .cfg  (cfg),
    .res  (res_comb)
  );

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_comb;
    end
  end

endmodule

// ----- rtl/core/pet_axis.sv -----
// One cursor axis: add the signed delta and clamp to the screen dimension.
`timescale 1ns / 1ps
module pet_axis #(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]  pos,
  input  logic signed [31:0]     delta,
  input  logic                   invert,
  input  logic [pet_pkg::DIM_W-1:0] dim,
  output logic [COORD_BITS-1:0]  pos_next
);
  import pet_pkg::*;

  localparam int SumW = (COORD_BITS > 32 ? COORD_BITS : 32) + 2;
  localparam int DimW = (COORD_BITS + 1 > DIM_W ? COORD_BITS + 1 : DIM_W);
  localparam logic [DimW-1:0] MaxDim = DimW'(1) << COORD_BITS;

  logic [DimW-1:0]       dim_ext;
  logic [DimW-1:0]       lim_wide;
  logic [COORD_BITS:0]   lim;
  logic signed [SumW-1:0] pos_s;
  logic signed [SumW-1:0] delta_s;
  logic signed [SumW-1:0] sum;
  logic signed [SumW-1:0] lim_s;

  // Bound the dimension to 1 .. 2^COORD_BITS
  always_comb begin
    dim_ext = DimW'(dim);
    if (dim_ext == '0) begin
      lim_wide = DimW'(1);
    end else if (dim_ext > MaxDim) begin
      lim_wide = MaxDim;
    end else begin
      lim_wide = dim_ext;
    end
    lim = lim_wide[COORD_BITS:0];
  end

  // Exact sum, then clamp high first and low second
  always_comb begin
    pos_s   = $signed(SumW'(pos));
    delta_s = SumW'(delta);
    sum     = invert ? (pos_s - delta_s) : (pos_s + delta_s);
    lim_s   = $signed(SumW'(lim));
    if (sum >= lim_s) begin
      pos_next = COORD_BITS'(lim - 1'b1);
    end else if (sum < 0) begin
      pos_next = '0;
    end else begin
      pos_next = sum[COORD_BITS-1:0];
    end
  end

endmodule

// ----- rtl/core/pet_core.sv -----
// Event decode, cursor, button and double-click state: one event a cycle on fire.
`timescale 1ns / 1ps
module pet_core #(
  parameter int COORD_BITS = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  pet_pkg::event_t  evt,
  input  pet_pkg::cfg_t    cfg,
  output pet_pkg::result_t res
);
  import pet_pkg::*;

  logic [COORD_BITS-1:0] cursor_x, cursor_x_next;
  logic [COORD_BITS-1:0] cursor_y, cursor_y_next;
  logic                  press_level, press_level_next;
  logic                  last_button, last_button_next;
  logic [1:0]            click_counter, click_counter_next;
  logic [31:0]           prev_press_time, prev_press_time_next;
  logic                  double_flag, double_flag_next;

  logic                  rot;
  logic [9:0]            code_x;
  logic [9:0]            code_y;
  logic [DIM_W-1:0]      dim_x;
  logic [DIM_W-1:0]      dim_y;
  logic [COORD_BITS-1:0] moved_x;
  logic [COORD_BITS-1:0] moved_y;
  logic signed [48:0]    prod;
  logic [31:0]           gap;
  logic                  gap_ok;
  logic [1:0]            count_inc;
  logic                  level_ok;
  logic                  lvl;

  // Swap axes and dimensions under rotation
  always_comb begin
    rot    = cfg.rotation != 2'd0;
    code_x = rot ? CODE_Y : CODE_X;
    code_y = rot ? CODE_X : CODE_Y;
    dim_x  = rot ? cfg.screen_height : cfg.screen_width;
    dim_y  = rot ? cfg.screen_width : cfg.screen_height;
  end

  pet_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .pos      (cursor_x),
    .delta    (evt.event_value),
    .invert   (cfg.rotation == ROT_INV_X),
    .dim      (dim_x),
    .pos_next (moved_x)
  );

  pet_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .pos      (cursor_y),
    .delta    (evt.event_value),
    .invert   (cfg.rotation == ROT_INV_Y),
    .dim      (dim_y),
    .pos_next (moved_y)
  );

  // Wheel scaling: unsigned step times signed value
  assign prod = $signed({1'b0, cfg.wheel_step}) * $signed(evt.event_value);

  // Double-click gap, modulo 2^32
  assign gap       = evt.time_ms - prev_press_time;
  assign gap_ok    = gap < {16'd0, cfg.double_click_ms};
  assign count_inc = click_counter + 2'd1;
  assign level_ok  = (evt.event_value == 32'sd0) || (evt.event_value == 32'sd1);
  assign lvl       = evt.event_value[0];

  // Decode the event and form next state and result
  always_comb begin
    cursor_x_next        = cursor_x;
    cursor_y_next        = cursor_y;
    press_level_next     = press_level;
    last_button_next     = last_button;
    click_counter_next   = click_counter;
    prev_press_time_next = prev_press_time;
    double_flag_next     = double_flag;
    res.activity         = 1'b0;
    res.step_change_req  = 1'b0;
    res.wheel_turn       = '0;
    res.tune_delta       = '0;

    if (evt.event_type == EV_MOTION) begin
      if (evt.event_code == CODE_WHEEL) begin
        res.wheel_turn = evt.event_value;
        res.tune_delta = prod[47:0];
      end else if (evt.event_code == code_x) begin
        cursor_x_next = moved_x;
        res.activity  = 1'b1;
      end else if (evt.event_code == code_y) begin
        cursor_y_next = moved_y;
        res.activity  = 1'b1;
      end
    end else if (evt.event_type == EV_BUTTON && level_ok) begin
      if (evt.event_code == CODE_MIDDLE) begin
        res.step_change_req = lvl;
      end else if (evt.event_code == CODE_RIGHT) begin
        press_level_next = lvl;
        last_button_next = 1'b1;
        res.activity     = 1'b1;
      end else if (evt.event_code == CODE_LEFT) begin
        press_level_next = lvl;
        last_button_next = 1'b0;
        res.activity     = 1'b1;
        if (lvl) begin
          if (gap_ok) begin
            if (count_inc == 2'd2) begin
              click_counter_next = 2'd0;
              double_flag_next   = 1'b1;
            end else begin
              click_counter_next = count_inc;
            end
          end else begin
            click_counter_next = 2'd1;
            double_flag_next   = 1'b0;
          end
          prev_press_time_next = evt.time_ms;
        end
      end
    end

    res.pos_x        = POS_W'(cursor_x_next);
    res.pos_y        = POS_W'(cursor_y_next);
    res.pressed      = press_level_next;
    res.button_id    = last_button_next;
    res.double_click = double_flag_next;
  end

  // Commit state when the event moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x        <= '0;
      cursor_y        <= '0;
      press_level     <= 1'b0;
      last_button     <= 1'b0;
      click_counter   <= 2'd0;
      prev_press_time <= 32'd0;
      double_flag     <= 1'b0;
    end else if (fire) begin
      cursor_x        <= cursor_x_next;
      cursor_y        <= cursor_y_next;
      press_level     <= press_level_next;
      last_button     <= last_button_next;
      click_counter   <= click_counter_next;
      prev_press_time <= prev_press_time_next;
      double_flag     <= double_flag_next;
    end
  end

endmodule

// ----- rtl/core/pet_checker.sv -----
// Port-level checks for the pointer event tracker, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pet_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         evt_valid,
  input logic                         evt_stall,
  input logic                         res_valid,
  input logic                         res_stall,
  input pet_pkg::result_t             res
);
  import pet_pkg::*;

  // Reset empties the result register
  `PET_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !res_valid, "result valid after reset")

  // An accepted beat passes the event register, then the result register is valid
  `PET_ASSERT(a_latency, clk, rst, evt_valid && !evt_stall |=> ##1 res_valid, "result missing")

  // Intake never stalls while the result side is empty
  `PET_ASSERT(a_no_idle_stall, clk, rst, !res_valid |-> !evt_stall, "stall with empty output")

  // A stalled result holds
  `PET_ASSERT(a_res_hold, clk, rst, res_valid && res_stall |=> res_valid && $stable(res), "result changed under stall")

  // A step-change request is never a wheel or activity event
  `PET_ASSERT(a_step_req_excl, clk, rst, res_valid && res.step_change_req |-> !res.activity && res.wheel_turn == 32'sd0, "step request mixed with other event")

endmodule

bind pointer_event_tracker pet_checker u_pet_checker (.*);

// ----- tb/pointer_event_tracker_tb.sv -----
// Self-checking testbench for the pointer event tracker: directed table, then random phases.
`timescale 1ns / 1ps
module pointer_event_tracker_tb;
  import pet_pkg::*;

  localparam int COORD = 12;
  localparam int MAX_DIM = 1 << COORD;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int PHASE_EVENTS = 70;

  // Codes the package leaves unnamed.
  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_SWAP = 2'd2;
  localparam logic [4:0] EV_NONE = 5'd0;
  localparam logic [4:0] EV_UNKNOWN = 5'd31;
  localparam logic [9:0] CODE_UNKNOWN = 10'd767;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd5;
  localparam logic signed [31:0] LVL_RELEASE = 32'sd0;
  localparam logic signed [31:0] LVL_PRESS = 32'sd1;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    event_t  ev;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic evt_valid = 1'b0;
  logic evt_stall;
  event_t evt = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  result_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pointer_event_tracker #(.COORD_BITS(COORD)) dut (
    .clk(clk),
    .rst(rst),
    .evt_valid(evt_valid),
    .evt_stall(evt_stall),
    .evt(evt),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tracker copy: settings and pointer state.
  cfg_t settings;
  logic [POS_W-1:0] cur_x, cur_y;
  logic press_lvl, btn_last, dbl_flag;
  logic [1:0] clicks;
  logic [31:0] last_click_ms;

  result_t pending_results[$];
  stim_row_t dir_rows[$];

  int errors = 0;
  int results_seen = 0;
  int input_held = 0;
  int reg_writes = 0;
  int random_events = 0;
  int double_hits = 0;
  int wheel_events = 0;
  int send_idle_pct = 38;
  int recv_idle_pct = 88;
  int hold_requests = 0;
  logic [31:0] ms_now = 32'd0;

  function automatic event_t make_event(logic [4:0] ty, logic [9:0] code,
                                        logic signed [31:0] value, logic [31:0] ms);
    event_t e;
    e.event_type = ty;
    e.event_code = code;
    e.event_value = value;
    e.time_ms = ms;
    return e;
  endfunction

  // Result right after reset: no button or click history yet.
  function automatic result_t typed_result(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                           logic act, logic signed [31:0] wh,
                                           logic signed [47:0] tn);
    result_t r;
    r = '0;
    r.pos_x = x;
    r.pos_y = y;
    r.activity = act;
    r.wheel_turn = wh;
    r.tune_delta = tn;
    return r;
  endfunction

  // Append one row to the directed table.
  task automatic add_row(input event_t ev, input bit typed, input result_t want);
    stim_row_t row;
    row.ev = ev;
    row.typed = typed;
    row.want = want;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  function automatic longint dim_bound(logic [DIM_W-1:0] d);
    if (d == '0) return 1;
    if (int'(d) > MAX_DIM) return MAX_DIM;
    return longint'(d);
  endfunction

  // Move one axis by the exact delta, then clamp to [0, dim - 1].
  function automatic logic [POS_W-1:0] step_axis(logic [POS_W-1:0] pos, longint delta,
                                                 bit invert, logic [DIM_W-1:0] dim);
    longint n, d;
    n = longint'(pos) + (invert ? -delta : delta);
    d = dim_bound(dim);
    if (n >= d) n = d - 1;
    if (n < 0) n = 0;
    return n[POS_W-1:0];
  endfunction

  // Apply one event to the tracker copy and form its result.
  task automatic track_pointer(input event_t e, output result_t r);
    logic rot;
    logic [9:0] code_x, code_y;
    logic [DIM_W-1:0] dim_x, dim_y;
    longint delta, product;
    logic [31:0] gap;
    rot = settings.rotation != ROT_NONE;
    code_x = rot ? CODE_Y : CODE_X;
    code_y = rot ? CODE_X : CODE_Y;
    dim_x = rot ? settings.screen_height : settings.screen_width;
    dim_y = rot ? settings.screen_width : settings.screen_height;
    delta = longint'(e.event_value);
    r = '0;
    if (e.event_type == EV_MOTION) begin
      if (e.event_code == CODE_WHEEL) begin
        product = longint'(settings.wheel_step) * delta;
        r.wheel_turn = e.event_value;
        r.tune_delta = product[47:0];
        wheel_events++;
      end else if (e.event_code == code_x) begin
        cur_x = step_axis(cur_x, delta, settings.rotation == ROT_INV_X, dim_x);
        r.activity = 1'b1;
      end else if (e.event_code == code_y) begin
        cur_y = step_axis(cur_y, delta, settings.rotation == ROT_INV_Y, dim_y);
        r.activity = 1'b1;
      end
    end else if (e.event_type == EV_BUTTON &&
                 (e.event_value == LVL_RELEASE || e.event_value == LVL_PRESS)) begin
      if (e.event_code == CODE_MIDDLE) begin
        r.step_change_req = e.event_value[0];
      end else if (e.event_code == CODE_RIGHT) begin
        press_lvl = e.event_value[0];
        btn_last = 1'b1;
        r.activity = 1'b1;
      end else if (e.event_code == CODE_LEFT) begin
        press_lvl = e.event_value[0];
        btn_last = 1'b0;
        r.activity = 1'b1;
        // Count quick left presses; two in a row make a double click.
        if (e.event_value == LVL_PRESS) begin
          gap = e.time_ms - last_click_ms;
          if (gap < {16'd0, settings.double_click_ms}) begin
            clicks = clicks + 2'd1;
            if (clicks == 2'd2) begin
              clicks = 2'd0;
              dbl_flag = 1'b1;
              double_hits++;
            end
          end else begin
            clicks = 2'd1;
            dbl_flag = 1'b0;
          end
          last_click_ms = e.time_ms;
        end
      end
    end
    r.pos_x = cur_x;
    r.pos_y = cur_y;
    r.pressed = press_lvl;
    r.button_id = btn_last;
    r.double_click = dbl_flag;
  endtask

  // Write one setting; starts and ends on a falling edge.
  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SCREEN_WIDTH:    settings.screen_width = data[DIM_W-1:0];
      REG_SCREEN_HEIGHT:   settings.screen_height = data[DIM_W-1:0];
      REG_ROTATION:        settings.rotation = data[1:0];
      REG_WHEEL_STEP:      settings.wheel_step = data;
      REG_DOUBLE_CLICK_MS: settings.double_click_ms = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one event beat, with random idle cycles ahead of it.
  task automatic push_event(input event_t e, input bit typed, input result_t want);
    result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      evt_valid <= 1'b0;
      @(negedge clk);
    end
    evt <= e;
    evt_valid <= 1'b1;
    @(posedge clk);
    while (evt_stall) @(posedge clk);
    track_pointer(e, predicted);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Check each result beat against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (evt_valid && evt_stall === 1'b1) input_held++;
      if (res_valid === 1'b1 && !res_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t ns: result with nothing expected, actual %h", $time, res);
          errors++;
        end else begin
          want = pending_results.pop_front();
          compare_field("pos_x", want.pos_x, res.pos_x);
          compare_field("pos_y", want.pos_y, res.pos_y);
          compare_field("pressed", want.pressed, res.pressed);
          compare_field("button_id", want.button_id, res.button_id);
          compare_field("double_click", want.double_click, res.double_click);
          compare_field("activity", want.activity, res.activity);
          compare_field("wheel_turn", want.wheel_turn, res.wheel_turn);
          compare_field("tune_delta", want.tune_delta, res.tune_delta);
          compare_field("step_change_req", want.step_change_req, res.step_change_req);
        end
      end
    end
  end

  // Drive the result stall: random, or a long hold-off on request.
  int hold_served = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    settings.screen_width = RST_SCREEN_WIDTH;
    settings.screen_height = RST_SCREEN_HEIGHT;
    settings.rotation = RST_ROTATION;
    settings.wheel_step = RST_WHEEL_STEP;
    settings.double_click_ms = RST_DOUBLE_CLICK_MS;
    cur_x = '0;
    cur_y = '0;
    press_lvl = 1'b0;
    btn_last = 1'b0;
    clicks = 2'd0;
    last_click_ms = 32'd0;
    dbl_flag = 1'b0;

    // Directed table: reset settings 800x480, no rotation, step 1, 300 ms.
    add_row(make_event(EV_MOTION, CODE_X, VAL_MIN, 32'd0), 1'b1,
            typed_result(12'd0, 12'd0, 1'b1, 32'sd0, 48'sd0));
    add_row(make_event(EV_MOTION, CODE_X, VAL_MAX, 32'd0), 1'b1,
            typed_result(12'd799, 12'd0, 1'b1, 32'sd0, 48'sd0));
    add_row(make_event(EV_MOTION, CODE_Y, VAL_MAX, 32'd0), 1'b1,
            typed_result(12'd799, 12'd479, 1'b1, 32'sd0, 48'sd0));
    add_row(make_event(EV_MOTION, CODE_WHEEL, VAL_MIN, 32'd0), 1'b1,
            typed_result(12'd799, 12'd479, 1'b0, VAL_MIN, -48'sd2147483648));
    add_row(make_event(EV_MOTION, CODE_WHEEL, VAL_MAX, 32'd0), 1'b1,
            typed_result(12'd799, 12'd479, 1'b0, VAL_MAX, 48'sd2147483647));
    add_row(make_event(EV_MOTION, CODE_Y, -32'sd5, 32'd1), 1'b0, '0);
    add_row(make_event(EV_MOTION, CODE_X, 32'sd0, 32'd2), 1'b0, '0);
    add_row(make_event(EV_MOTION, CODE_WHEEL, 32'sd0, 32'd3), 1'b0, '0);
    // Unknown codes and classes report the held state.
    add_row(make_event(EV_MOTION, CODE_UNKNOWN, 32'sd100, 32'd4), 1'b0, '0);
    add_row(make_event(EV_NONE, CODE_X, LVL_PRESS, 32'd5), 1'b0, '0);
    add_row(make_event(EV_UNKNOWN, CODE_UNKNOWN, -32'sd1, 32'hffff_ffff), 1'b0, '0);
    add_row(make_event(EV_BUTTON, CODE_MIDDLE, LVL_PRESS, 32'd10), 1'b0, '0);
    add_row(make_event(EV_BUTTON, CODE_MIDDLE, LVL_RELEASE, 32'd11), 1'b0, '0);
    add_row(make_event(EV_BUTTON, CODE_RIGHT, LVL_PRESS, 32'd12), 1'b0, '0);
    add_row(make_event(EV_BUTTON, CODE_RIGHT, LVL_RELEASE, 32'd13), 1'b0, '0);
    // Left presses: quick pair, slow press, then a pair across the timestamp wrap.
    add_row(make_event(EV_BUTTON, CODE_LEFT, LVL_PRESS, 32'd100), 1'b0, '0);
    add_row(make_event(EV_BUTTON, CODE_LEFT, LVL_RELEASE, 32'd150), 1'b0, '0);
    add_row(make_event(EV_BUTTON, CODE_LEFT, LVL_PRESS, 32'd350), 1'b0, '0);
    add_row(make_event(EV_BUTTON, CODE_LEFT, LVL_PRESS, 32'd1000), 1'b0, '0);
    // Button levels other than press and release are dropped.
    add_row(make_event(EV_BUTTON, CODE_LEFT, 32'sd2, 32'd1100), 1'b0, '0);
    add_row(make_event(EV_BUTTON, CODE_LEFT, -32'sd1, 32'd1200), 1'b0, '0);
    add_row(make_event(EV_BUTTON, CODE_LEFT, LVL_PRESS, 32'd1299), 1'b0, '0);
    add_row(make_event(EV_BUTTON, CODE_LEFT, LVL_PRESS, 32'hffff_fff0), 1'b0, '0);
    add_row(make_event(EV_BUTTON, CODE_LEFT, LVL_PRESS, 32'h0000_0010), 1'b0, '0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) push_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want);
    evt_valid <= 1'b0;
    wait_for_results();

    for (int phase = 0; phase < 6; phase++) begin
      // Idle mix per pair of phases: sender-light, receiver-light, none.
      case (phase / 2)
        0: begin
          send_idle_pct <= 38;
          recv_idle_pct <= 88;
        end
        1: begin
          send_idle_pct <= 88;
          recv_idle_pct <= 38;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      case (phase)
        0: begin
          write_setting(REG_SCREEN_WIDTH, 16'd1);
          write_setting(REG_SCREEN_HEIGHT, 16'd1);
          write_setting(REG_ROTATION, {14'd0, ROT_NONE});
          write_setting(REG_WHEEL_STEP, 16'd0);
          write_setting(REG_DOUBLE_CLICK_MS, 16'd1);
        end
        1: begin
          write_setting(REG_SCREEN_WIDTH, 16'(MAX_DIM));
          write_setting(REG_SCREEN_HEIGHT, 16'(MAX_DIM));
          write_setting(REG_ROTATION, {14'd0, ROT_INV_X});
          write_setting(REG_WHEEL_STEP, 16'hffff);
          write_setting(REG_DOUBLE_CLICK_MS, 16'hffff);
        end
        2: begin
          // Zero width acts as one; oversized height acts as the full range.
          write_setting(REG_SCREEN_WIDTH, 16'd0);
          write_setting(REG_SCREEN_HEIGHT, 16'hffff);
          write_setting(REG_ROTATION, {14'd0, ROT_INV_Y});
          write_setting(REG_WHEEL_STEP, 16'($urandom()));
          write_setting(REG_DOUBLE_CLICK_MS, 16'd0);
        end
        3: begin
          write_setting(REG_SCREEN_WIDTH, 16'($urandom_range(1, 640)));
          write_setting(REG_SCREEN_HEIGHT, 16'($urandom_range(1, 640)));
          write_setting(REG_ROTATION, {14'd0, ROT_SWAP});
          write_setting(REG_WHEEL_STEP, 16'($urandom()));
          write_setting(REG_DOUBLE_CLICK_MS, 16'($urandom_range(50, 2000)));
        end
        default: begin
          write_setting(REG_SCREEN_WIDTH, 16'($urandom_range(1, MAX_DIM)));
          write_setting(REG_SCREEN_HEIGHT, 16'($urandom_range(1, MAX_DIM)));
          write_setting(REG_ROTATION, 16'($urandom_range(0, 3)));
          write_setting(REG_WHEEL_STEP, 16'($urandom()));
          write_setting(REG_DOUBLE_CLICK_MS, 16'($urandom_range(1, 3000)));
          write_setting(REG_NONE + 3'($urandom_range(0, 2)), 16'($urandom()));
        end
      endcase
      // Starve the result side once so both stages fill and intake stalls.
      if (phase == 4) hold_requests <= hold_requests + 1;

      for (int n = 0; n < PHASE_EVENTS; n++) begin : gen
        event_t e;
        int r, span;
        r = $urandom_range(0, 99);
        span = ($urandom_range(0, 3) == 0) ? 5000 : 40;
        if ($urandom_range(0, 49) == 0) ms_now = $urandom();
        else ms_now += $urandom_range(0, 2 * settings.double_click_ms + 3);
        e = make_event(EV_BUTTON, CODE_LEFT, LVL_PRESS, ms_now);
        if (r < 35) begin
          // Cursor motion, mostly small steps, sometimes a jump to the edges.
          e.event_type = EV_MOTION;
          e.event_code = $urandom_range(0, 1) ? CODE_Y : CODE_X;
          if ($urandom_range(0, 9) == 0) e.event_value = $urandom();
          else e.event_value = int'($urandom_range(0, 2 * span)) - span;
        end else if (r < 45) begin
          e.event_type = EV_MOTION;
          e.event_code = CODE_WHEEL;
          if ($urandom_range(0, 1)) e.event_value = $urandom();
          else e.event_value = int'($urandom_range(0, 20)) - 10;
        end else if (r < 70) begin
          if ($urandom_range(0, 99) >= 65) e.event_value = LVL_RELEASE;
        end else if (r < 80) begin
          e.event_code = $urandom_range(0, 1) ? CODE_RIGHT : CODE_MIDDLE;
          e.event_value = $urandom_range(0, 1) ? LVL_PRESS : LVL_RELEASE;
        end else if (r < 90) begin
          // Button beat with a broken level or an unknown code.
          e.event_code = $urandom_range(0, 3) == 0 ? 10'($urandom()) :
                         (CODE_LEFT + 10'($urandom_range(0, 2)));
          e.event_value = $urandom();
        end else begin
          e.event_type = 5'($urandom());
          e.event_code = 10'($urandom());
          e.event_value = $urandom();
          e.time_ms = $urandom();
        end
        random_events++;
        push_event(e, 1'b0, '0);
      end
      evt_valid <= 1'b0;
      wait_for_results();
    end

    repeat (4) @(negedge clk);
    $display("Ran %0d directed and %0d random events through 6 setting phases, %0d writes.",
             dir_rows.size(), random_events, reg_writes);
    $display("Checked %0d results: %0d double clicks, %0d wheel beats, %0d input stall cycles.",
             results_seen, double_hits, wheel_events, input_held);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/pet_pkg.sv
rtl/core/pet_axis.sv
rtl/core/pet_core.sv
rtl/core/pointer_event_tracker.sv
rtl/core/pet_checker.sv
tb/pointer_event_tracker_tb.sv
